>>> hdl/ssip_pkg.sv
// Shared types, codes and defaults for the sorted set insert/pop block.
package ssip_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;

  // Fixed field widths on the ports
  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 5;
  localparam int OUT_DATA_W   = 40;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic execute;  // apply the latched item and load the result
  } ctrl_cmd_t;

endpackage

>>> hdl/sorted_set_insert_pop.sv
// Top level of the sorted set insert/pop block.
//
// Keeps up to CAPACITY distinct keys in sorted order, smallest first, or
// largest first while the order register is set.
// Input channel (in_*): in_tuser is the command (0 insert, 1 pop), in_tdata
// the key. Each item gives exactly one result item.
// Result channel (out_*): out_tuser is the status (ok, duplicate, underflow,
// full), out_tdata carries the front key, its valid bit and the count.
// Configuration: pulse cfg_wr_en with cfg_wr_data to set the order; write
// only while no item is in flight. Held keys are not re-sorted.
// Sequence: the item is captured into the key and command registers, then
// the whole register row compares and shifts in parallel as the result
// register loads; no new item is taken until that execute step is done.
// Reset (rst_n low, synchronous): store empty, ascending order, no result.
// Stall: a result waits in the output register while out_tready is low; a
// new item is taken in the cycle the waiting result is taken, not before.
module sorted_set_insert_pop #(
  parameter int CAPACITY  = ssip_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = ssip_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,  // descending_order
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssip_pkg::KEY_PORT_W-1:0]     in_tdata,     // key
  input  logic                                in_tuser,     // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // front_key [31:0], front_valid [32], entry_count [37:33], zero [39:38]
  output logic [ssip_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [ssip_pkg::STATUS_W-1:0]       out_tuser     // status
);
  import ssip_pkg::*;

  ctrl_cmd_t                cmd;
  logic [STATUS_W-1:0]      res_status;
  logic [KEY_PORT_W-1:0]    res_front_key;
  logic                     res_front_valid;
  logic [COUNT_PORT_W-1:0]  res_count;

  // Sequence: capture the item, then execute and load the result register
  ssip_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Hold the keys, order register and result payload
  ssip_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_tuser),
    .in_key          (in_tdata),
    .res_status      (res_status),
    .res_front_key   (res_front_key),
    .res_front_valid (res_front_valid),
    .res_count       (res_count)
  );

  // Pack the result fields, lowest first, pad to whole bytes
  assign out_tdata = {2'b00, res_count, res_front_valid, res_front_key};
  assign out_tuser = res_status;

endmodule

>>> hdl/ssip_ctrl.sv
// Controller state machine: input handshake, sequencing and result valid.
module ssip_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output ssip_pkg::ctrl_cmd_t  cmd
);
  import ssip_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  // Take an item only while idle and when the result slot is free or drains this cycle
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/ssip_dpath.sv
// Datapath: sorted register row with parallel compare, count and result registers.
module ssip_dpath #(
  parameter int CAPACITY  = ssip_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = ssip_pkg::DEF_KEY_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ssip_pkg::ctrl_cmd_t                  cmd,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_wr_data,
  input  logic                                 in_cmd,
  input  logic [ssip_pkg::KEY_PORT_W-1:0]      in_key,
  output logic [ssip_pkg::STATUS_W-1:0]        res_status,
  output logic [ssip_pkg::KEY_PORT_W-1:0]      res_front_key,
  output logic                                 res_front_valid,
  output logic [ssip_pkg::COUNT_PORT_W-1:0]    res_count
);
  import ssip_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 desc_r;
  logic                 cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] ent_r   [CAPACITY];
  logic [KEY_WIDTH-1:0] ent_nxt [CAPACITY];
  logic [KEY_WIDTH-1:0] prev    [CAPACITY];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [CAPACITY-1:0]  valid, ahead, equal, stop, cum, first;
  logic                 dup, full, empty;
  logic [STATUS_W-1:0]  status;

  logic [STATUS_W-1:0]     status_r;
  logic [KEY_PORT_W-1:0]   front_key_r;
  logic                    front_valid_r;
  logic [COUNT_PORT_W-1:0] count_r;

  // Compare every held entry against the key at once
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CNT_W'(i) < cnt_r;
      ahead[i] = desc_r ? (ent_r[i] > key_r) : (ent_r[i] < key_r);
      equal[i] = ent_r[i] == key_r;
      stop[i]  = !valid[i] || !ahead[i];
    end
    cum[0]   = stop[0];
    first[0] = stop[0];
    prev[0]  = key_r;
    for (int i = 1; i < CAPACITY; i++) begin
      cum[i]   = cum[i-1] | stop[i];
      first[i] = stop[i] & !cum[i-1];
      prev[i]  = ent_r[i-1];
    end
  end

  assign dup   = |(first & valid & equal);
  assign full  = cnt_r == CNT_W'(CAPACITY);
  assign empty = cnt_r == '0;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt = cnt_r;
    status  = STAT_OK;
    if (cmd_r == CMD_POP) begin
      if (empty) begin
        status = STAT_UNDER;
      end else begin
        // Advance every entry one place toward the front
        for (int i = 0; i < CAPACITY - 1; i++) begin
          ent_nxt[i] = ent_r[i+1];
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else if (dup) begin
      status = STAT_DUP;
    end else if (full) begin
      status = STAT_FULL;
    end else begin
      // Hold entries ahead of the key, drop the key in, shift the rest back
      for (int i = 0; i < CAPACITY; i++) begin
        if (!cum[i]) begin
          ent_nxt[i] = ent_r[i];
        end else if (first[i]) begin
          ent_nxt[i] = key_r;
        end else begin
          ent_nxt[i] = prev[i];
        end
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        desc_r <= cfg_wr_data;
      end
      if (cmd.execute) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      key_r <= KEY_WIDTH'(in_key);
    end
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
      status_r      <= status;
      front_key_r   <= (cnt_nxt != '0) ? KEY_PORT_W'(ent_nxt[0]) : '0;
      front_valid_r <= cnt_nxt != '0;
      count_r       <= COUNT_PORT_W'(cnt_nxt);
    end
  end

  assign res_status      = status_r;
  assign res_front_key   = front_key_r;
  assign res_front_valid = front_valid_r;
  assign res_count       = count_r;

endmodule

>>> dv/sorted_set_insert_pop_tb.sv
// Self-checking testbench for the sorted set insert/pop block.
`timescale 1ns / 100ps

module sorted_set_insert_pop_tb;
  import ssip_pkg::*;

  localparam int SET_DEPTH    = DEF_CAPACITY;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 88;
  localparam int DRAIN_CYCLES = 6;       // slack after the last result
  localparam int CYCLE_LIMIT  = 400000;  // watchdog bound on the length of the whole run

  // One expected result item, split into the fields of out_tuser / out_tdata
  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic [KEY_PORT_W-1:0]   front_key;
    logic                    front_valid;
    logic [COUNT_PORT_W-1:0] entry_count;
  } set_result_t;

  // Tracks the ordered key store and holds the results it predicts until the
  // block delivers them.
  class sorted_key_scoreboard;
    logic [KEY_PORT_W-1:0] keys [SET_DEPTH];
    int                    held;
    bit                    descending;
    set_result_t           pending_results [$];
    int                    mismatches;
    int                    items_seen;
    int                    peak_held;
    int                    status_tally [4];

    function new();
      held = 0;
      descending = 1'b0;
      mismatches = 0;
      items_seen = 0;
      peak_held = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // true when a must sit strictly in front of b under the current order
    function bit key_ahead(logic [KEY_PORT_W-1:0] a, logic [KEY_PORT_W-1:0] b);
      return descending ? (a > b) : (a < b);
    endfunction

    function void record_command(logic cmd, logic [KEY_PORT_W-1:0] key);
      int pos;
      logic [STATUS_W-1:0] st;
      set_result_t r;
      if (cmd == CMD_INSERT) begin
        pos = 0;
        while (pos < held && key_ahead(keys[pos], key)) pos++;
        if (pos < held && !key_ahead(key, keys[pos])) begin
          st = STAT_DUP;
        end else if (held >= SET_DEPTH) begin
          st = STAT_FULL;
        end else begin
          for (int i = held; i > pos; i--) keys[i] = keys[i-1];
          keys[pos] = key;
          held++;
          st = STAT_OK;
        end
      end else if (held == 0) begin
        st = STAT_UNDER;
      end else begin
        for (int i = 0; i < held - 1; i++) keys[i] = keys[i+1];
        held--;
        st = STAT_OK;
      end
      r.status      = st;
      r.front_valid = (held != 0);
      r.front_key   = (held != 0) ? keys[0] : '0;
      r.entry_count = held[COUNT_PORT_W-1:0];
      pending_results.push_back(r);
      status_tally[st]++;
      items_seen++;
      if (held > peak_held) peak_held = held;
    endfunction

    function void check_field(string field, logic [KEY_PORT_W-1:0] want,
                              logic [KEY_PORT_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void compare_result(logic [STATUS_W-1:0] status,
                                 logic [OUT_DATA_W-1:0] data);
      set_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d data %h",
                 $time, status, data);
        return;
      end
      // Take the oldest prediction off the queue
      want = pending_results[0];
      pending_results.delete(0);
      check_field("status", KEY_PORT_W'(want.status), KEY_PORT_W'(status));
      check_field("front_key", want.front_key, data[31:0]);
      check_field("front_valid", KEY_PORT_W'(want.front_valid), KEY_PORT_W'(data[32]));
      check_field("entry_count", KEY_PORT_W'(want.entry_count),
                  KEY_PORT_W'(data[37:33]));
      check_field("pad bits", '0, KEY_PORT_W'(data[39:38]));
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [KEY_PORT_W-1:0]   in_tdata;   // key
  logic                    in_tuser;   // command
  logic                    out_tvalid;
  logic                    out_tready;
  // front_key [31:0], front_valid [32], entry_count [37:33], zero [39:38]
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [STATUS_W-1:0]     out_tuser;  // status

  sorted_key_scoreboard sb;
  int stall_pct;      // chance per cycle that the result side starts a stall
  int gap_pct;        // chance per item that the sender idles first
  int order_writes;
  int cycle_count;

  sorted_set_insert_pop u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: one time in ten a long stretch, otherwise a short gap.
  function automatic int pick_idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Key mix: a narrow low pool and a narrow high pool provoke duplicates,
  // extremes hit the ordering edges, full-range keys toggle every bit.
  function automatic logic [KEY_PORT_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom_range(0, 31);
    if (sel < 40) begin
      case ($urandom_range(3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (sel < 60) return 32'hFFFF_FFE0 + $urandom_range(0, 31);
    return $urandom;
  endfunction

  // Result side: stall at random while stall_pct is nonzero, stay ready otherwise.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_tready <= 1'b0;
        stall_left = pick_idle_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check results first, then note new items: a result at this edge always
  // belongs to an earlier item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.compare_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.record_command(in_tuser, in_tdata);
    end
  end

  // Watchdog: fail the run once cycle_count reaches CYCLE_LIMIT, so a hang in the handshakes cannot run forever.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one item, optionally after an idle gap, and hold it until taken.
  // Valid stays high after the accepting edge; the next call either replaces
  // the item or drops valid at the following falling edge.
  task automatic send_item(input logic cmd, input logic [KEY_PORT_W-1:0] key);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? pick_idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the order register; only called while the block is idle.
  task automatic set_order(input bit desc);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    sb.descending = desc;
    order_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Directed opening: empty pop, fill with extremes, duplicate on the way,
  // duplicate into a full store, drop on full, then pop and refill the front.
  task automatic run_directed();
    logic [KEY_PORT_W-1:0] fill_keys [SET_DEPTH];
    fill_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0001, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h0000_0010, 32'h0001_0000, 32'h0100_0000, 32'hF000_0000,
                  32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h9ABC_DEF0, 32'h0000_0100};
    send_item(CMD_POP, 32'hDEAD_BEEF);
    foreach (fill_keys[i]) begin
      send_item(CMD_INSERT, fill_keys[i]);
      if (i == 3) send_item(CMD_INSERT, 32'h0000_0000);
    end
    send_item(CMD_INSERT, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, 32'h1234_5678);
    send_item(CMD_POP, 32'hFFFF_FFFF);
    send_item(CMD_POP, 32'h0000_0000);
    send_item(CMD_INSERT, 32'h0000_0000);
    drain();
  endtask

  // Random phase: bursts of inserts or pops so the store swings between
  // empty and full; the bias sets which way it tends to go.
  task automatic run_random_phase(input int insert_bias);
    int sent;
    int burst;
    bit inserting;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 20);
      inserting = ($urandom_range(99) < insert_bias);
      repeat (burst) begin
        if (inserting) send_item(CMD_INSERT, pick_key());
        else send_item(CMD_POP, $urandom);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    int phase_stall [PHASES];
    int phase_gap [PHASES];
    int phase_bias [PHASES];
    phase_stall = '{0, 25, 50, 10, 70, 0, 35, 15};
    phase_gap   = '{0, 40, 10, 60, 20, 0, 30, 50};
    phase_bias  = '{70, 50, 30, 80, 45, 65, 35, 55};
    sb = new();
    order_writes = 0;
    stall_pct = 0;
    gap_pct = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = CMD_INSERT;
    in_tdata = '0;

    // Hold reset low from the start, then release it for good.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    set_order(1'b0);
    stall_pct = 20;
    gap_pct = 20;
    run_directed();

    // Odd phases keep keys smallest first, even phases largest first; a
    // switch may come with keys still held, which then stay in the old order.
    for (int p = 0; p < PHASES; p++) begin
      set_order((p % 2) == 0);
      stall_pct = phase_stall[p];
      gap_pct = phase_gap[p];
      run_random_phase(phase_bias[p]);
    end

    $display("covered %0d items over %0d order writes, peak fill %0d of %0d",
             sb.items_seen, order_writes, sb.peak_held, SET_DEPTH);
    $display("outcomes: %0d ok, %0d duplicate, %0d underflow, %0d full drop",
             sb.status_tally[STAT_OK], sb.status_tally[STAT_DUP],
             sb.status_tally[STAT_UNDER], sb.status_tally[STAT_FULL]);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ssip_pkg.sv
hdl/ssip_ctrl.sv
hdl/ssip_dpath.sv
hdl/sorted_set_insert_pop.sv
dv/sorted_set_insert_pop_tb.sv
